### rtl/pst_pkg.sv
// Shared types, codes and defaults for the periodic subscription table.
package pst_pkg;

   // Default sizes handed to the top level
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF   = 32;

   // Reports returned by one tick at most
   localparam int MAX_RESULTS = 16;

   // Function codes of a request item
   localparam logic [1:0] FN_SUB   = 2'd0;
   localparam logic [1:0] FN_UNSUB = 2'd1;
   localparam logic [1:0] FN_TICK  = 2'd2;

   // Status codes of an acknowledgement
   localparam logic [2:0] ST_INSERTED    = 3'd0;
   localparam logic [2:0] ST_RENEWED     = 3'd1;
   localparam logic [2:0] ST_FULL        = 3'd2;
   localparam logic [2:0] ST_REMOVED     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
   localparam logic [2:0] ST_NOTHING_DUE = 3'd5;
   // Status carried by a report descriptor
   localparam logic [2:0] ST_REPORT      = 3'd0;

   // Register indexes of the control port
   localparam int         CSR_IDX_W    = 4;
   localparam logic [3:0] CSR_LIFETIME = 4'd0;
   localparam logic [3:0] CSR_OWN_ADDR = 4'd1;

   // Register reset values
   localparam logic [31:0] LIFETIME_RST = 32'd5000;
   localparam logic [7:0]  OWN_ADDR_RST = 8'd0;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  resource_id;
      logic [7:0]  dest_addr;
      logic [7:0]  report_type;
      logic [3:0]  payload_bytes;
      logic [15:0] period_ms;
      logic        with_lifetime;
   } pst_req_type;

   typedef struct packed {
      logic        is_report;
      logic [2:0]  status;
      logic [7:0]  report_resource;
      logic [7:0]  report_dest;
      logic [7:0]  report_source;
      logic [7:0]  report_kind;
      logic [3:0]  report_length;
      logic        last;
   } pst_rsp_type;

   // Requests from the scan engine to the response stage
   typedef struct packed {
      logic       rpt_valid;
      logic       fin_valid;
      logic [2:0] ack_status;
   } pst_stage_ctl_type;

   // Room left in the response stage
   typedef struct packed {
      logic can_report;
      logic can_finish;
   } pst_stage_sts_type;

endpackage

### rtl/pst_rsp_stage.sv
// Response staging: holds the newest report back until its last flag is known.
module pst_rsp_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  pst_pkg::pst_stage_ctl_type ctl,
   input  pst_pkg::pst_rsp_type       rpt,
   output pst_pkg::pst_stage_sts_type sts,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pst_pkg::pst_rsp_type       rsp_data
);

   logic                 out_valid_ff, out_valid_in;
   pst_pkg::pst_rsp_type out_ff, out_in;
   logic                 hold_valid_ff, hold_valid_in;
   pst_pkg::pst_rsp_type hold_ff, hold_in;
   pst_pkg::pst_rsp_type ack;
   logic                 out_free;

   assign out_free       = !out_valid_ff || !rsp_stall;
   assign sts.can_report = !hold_valid_ff || out_free;
   assign sts.can_finish = out_free;

   // Plain acknowledgement: only status and last are set
   always_comb begin
      ack        = '0;
      ack.status = ctl.ack_status;
      ack.last   = 1'b1;
   end

   // Report pushes the held one out; finish flushes held item or the ack
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (ctl.rpt_valid) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = hold_ff;
         end
         hold_valid_in = 1'b1;
         hold_in       = rpt;
      end else if (ctl.fin_valid) begin
         out_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
         if (hold_valid_ff) begin
            out_in      = hold_ff;
            out_in.last = 1'b1;
         end else begin
            out_in = ack;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### rtl/periodic_subscription_table.sv
// Top level: subscription table memory, scan engine, clock and control registers.
//
//   channel  direction  handshake         payload
//   req_     in         valid / stall     pst_req_type (func, resource, report setup)
//   rsp_     out        valid / stall     pst_rsp_type (ack or report descriptor)
//   csr_     in         valid / ready     csr_index, csr_wdata (lifetime, own address)
//
// The scan reads one table entry per cycle through the single read port, unless a report
// finds no room, and writes entries back compacted through the write port; an item is
// accepted, scanned and closed before its final result is given. A full subscribe skips
// the scan. Reports stall the scan only while the hold register is occupied and the
// output register is occupied and stalled.
// Reset clears the clock, the entry count and the control path; table contents
// are left as they are and are never read before being written.
module periodic_subscription_table #(
   parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEF,
   parameter int TIME_BITS   = pst_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pst_pkg::pst_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pst_pkg::pst_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int N_W   = $clog2(pst_pkg::MAX_RESULTS + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   typedef struct packed {
      logic [7:0]           resource;
      logic [7:0]           dest;
      logic [7:0]           kind;
      logic [3:0]           length;
      logic [15:0]          period;
      logic [TIME_BITS-1:0] next_due;
      logic [TIME_BITS-1:0] expiry;
      logic                 no_expiry;
   } entry_type;

   // Table memory and its registered read data
   entry_type entry_mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   logic [1:0]           state_ff, state_in;
   pst_pkg::pst_req_type req_ff, req_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [31:0]          lifetime_ff;
   logic [7:0]           own_addr_ff;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]     wr_idx_ff, wr_idx_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic                 found_ff, found_in;
   logic [N_W-1:0]       nrep_ff, nrep_in;

   logic                 rd_en;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;

   entry_type            ev;
   logic                 full, due, expired, match, keep_report;
   logic                 step, step_hold, scan_end, finish;
   logic [15:0]          sel_period;
   logic [TIME_BITS-1:0] resched, life_end;

   pst_pkg::pst_stage_ctl_type stage_ctl;
   pst_pkg::pst_stage_sts_type stage_sts;
   pst_pkg::pst_rsp_type       rpt;

   assign req_stall = reset || (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Per-entry decisions on the registered entry read from the table
   assign ev          = rd_data_ff;
   assign full        = cnt_ff >= CNT_W'(TABLE_DEPTH);
   assign due         = ev.next_due <= now_ff;
   assign expired     = !ev.no_expiry && (ev.expiry <= now_ff);
   assign match       = ev.resource == req_ff.resource_id;
   assign keep_report = due && (nrep_ff < N_W'(pst_pkg::MAX_RESULTS));
   assign sel_period  = (state_ff == S_SCAN) ? ev.period : req_ff.period_ms;
   assign resched     = now_ff + TIME_BITS'(sel_period);
   assign life_end    = now_ff + TIME_BITS'(lifetime_ff);

   // Scan pacing: one entry per cycle unless a report finds no room
   assign step_hold = (state_ff == S_SCAN) && ev_valid_ff && (req_ff.func == pst_pkg::FN_TICK)
                      && keep_report && !stage_sts.can_report;
   assign step      = (state_ff == S_SCAN) && ev_valid_ff && !step_hold;
   assign rd_en     = (state_ff == S_SCAN) && (rd_idx_ff < cnt_ff) && (!ev_valid_ff || step);
   assign scan_end  = (state_ff == S_SCAN)
                      && ((!ev_valid_ff && (rd_idx_ff == cnt_ff))
                          || (step && (req_ff.func == pst_pkg::FN_SUB) && match));
   assign finish    = (state_ff == S_FINISH) && stage_sts.can_finish;

   // Report descriptor of the entry under evaluation
   always_comb begin
      rpt                 = '0;
      rpt.is_report       = 1'b1;
      rpt.status          = pst_pkg::ST_REPORT;
      rpt.report_resource = ev.resource;
      rpt.report_dest     = ev.dest;
      rpt.report_source   = own_addr_ff;
      rpt.report_kind     = ev.kind;
      rpt.report_length   = ev.length;
      rpt.last            = 1'b0;
   end

   // Response stage requests and final status
   always_comb begin
      stage_ctl.rpt_valid = step && (req_ff.func == pst_pkg::FN_TICK) && keep_report;
      stage_ctl.fin_valid = finish;
      case (req_ff.func)
         pst_pkg::FN_SUB: begin
            if (full)
               stage_ctl.ack_status = pst_pkg::ST_FULL;
            else if (found_ff)
               stage_ctl.ack_status = pst_pkg::ST_RENEWED;
            else
               stage_ctl.ack_status = pst_pkg::ST_INSERTED;
         end
         pst_pkg::FN_UNSUB: begin
            stage_ctl.ack_status = found_ff ? pst_pkg::ST_REMOVED : pst_pkg::ST_NOT_FOUND;
         end
         default: stage_ctl.ack_status = pst_pkg::ST_NOTHING_DUE;
      endcase
   end

   // Write-back port: compaction during the scan, append at the finish
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_idx_ff[IDX_W-1:0];
      wr_data = ev;
      if (step) begin
         case (req_ff.func)
            pst_pkg::FN_SUB: begin
               if (match) begin
                  wr_en             = 1'b1;
                  wr_addr           = ev_idx_ff;
                  wr_data.period    = req_ff.period_ms;
                  wr_data.expiry    = life_end;
                  wr_data.no_expiry = 1'b0;
               end
            end
            pst_pkg::FN_UNSUB: begin
               wr_en = !(match && !found_ff);
            end
            pst_pkg::FN_TICK: begin
               if (due)
                  wr_data.next_due = resched;
               wr_en = !expired;
            end
            default: wr_en = 1'b0;
         endcase
      end else if (finish && (req_ff.func == pst_pkg::FN_SUB) && !full && !found_ff) begin
         wr_en             = 1'b1;
         wr_addr           = cnt_ff[IDX_W-1:0];
         wr_data.resource  = req_ff.resource_id;
         wr_data.dest      = req_ff.dest_addr;
         wr_data.kind      = req_ff.report_type;
         wr_data.length    = req_ff.payload_bytes;
         wr_data.period    = req_ff.period_ms;
         wr_data.next_due  = resched;
         wr_data.expiry    = life_end;
         wr_data.no_expiry = !req_ff.with_lifetime;
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      now_in      = now_ff;
      cnt_in      = cnt_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      ev_valid_in = ev_valid_ff;
      ev_idx_in   = ev_idx_ff;
      found_in    = found_ff;
      nrep_in     = nrep_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in      = req_data;
               rd_idx_in   = '0;
               wr_idx_in   = '0;
               ev_valid_in = 1'b0;
               found_in    = 1'b0;
               nrep_in     = '0;
               case (req_data.func)
                  pst_pkg::FN_SUB:   state_in = full ? S_FINISH : S_SCAN;
                  pst_pkg::FN_UNSUB: state_in = S_SCAN;
                  pst_pkg::FN_TICK: begin
                     now_in   = now_ff + TIME_BITS'(1);
                     state_in = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               ev_valid_in = 1'b1;
               ev_idx_in   = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
            end else if (step) begin
               ev_valid_in = 1'b0;
            end
            if (step) begin
               case (req_ff.func)
                  pst_pkg::FN_SUB: begin
                     if (match)
                        found_in = 1'b1;
                  end
                  pst_pkg::FN_UNSUB: begin
                     if (match && !found_ff)
                        found_in = 1'b1;
                     else
                        wr_idx_in = wr_idx_ff + CNT_W'(1);
                  end
                  pst_pkg::FN_TICK: begin
                     if (!expired)
                        wr_idx_in = wr_idx_ff + CNT_W'(1);
                     if (keep_report)
                        nrep_in = nrep_ff + N_W'(1);
                  end
                  default: found_in = found_ff;
               endcase
            end
            if (scan_end) begin
               ev_valid_in = 1'b0;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (finish) begin
               state_in = S_IDLE;
               case (req_ff.func)
                  pst_pkg::FN_SUB: begin
                     if (!full && !found_ff)
                        cnt_in = cnt_ff + CNT_W'(1);
                  end
                  pst_pkg::FN_UNSUB: cnt_in = wr_idx_ff;
                  pst_pkg::FN_TICK:  cnt_in = wr_idx_ff;
                  default:           cnt_in = cnt_ff;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         now_ff      <= '0;
         cnt_ff      <= '0;
         ev_valid_ff <= 1'b0;
         nrep_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         now_ff      <= now_in;
         cnt_ff      <= cnt_in;
         ev_valid_ff <= ev_valid_in;
         nrep_ff     <= nrep_in;
      end
      req_ff    <= req_in;
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      ev_idx_ff <= ev_idx_in;
      found_ff  <= found_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= pst_pkg::LIFETIME_RST;
         own_addr_ff <= pst_pkg::OWN_ADDR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pst_pkg::CSR_LIFETIME: lifetime_ff <= csr_wdata;
            pst_pkg::CSR_OWN_ADDR: own_addr_ff <= csr_wdata[7:0];
            default:               lifetime_ff <= lifetime_ff;
         endcase
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en)
         entry_mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= entry_mem[rd_idx_ff[IDX_W-1:0]];
   end

   pst_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stage_ctl),
      .rpt       (rpt),
      .sts       (stage_sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // Entry count stays within the table
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // A tick advances the clock by one before its scan
   a_tick_now: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.func == pst_pkg::FN_TICK))
      |=> (now_ff == $past(now_ff) + TIME_BITS'(1)))
      else $error("tick did not advance the clock");

   // Compaction never writes ahead of the entry under evaluation
   a_wr_behind: assert property (@(posedge clock) disable iff (reset)
      (step && wr_en) |-> (wr_addr <= ev_idx_ff))
      else $error("scan write overtook the read position");

   // Report count per tick stays within the limit
   a_nrep_bound: assert property (@(posedge clock) disable iff (reset)
      nrep_ff <= N_W'(pst_pkg::MAX_RESULTS))
      else $error("too many reports in one tick");
`endif

endmodule

### verif/periodic_subscription_table_tb.sv
// Self-checking testbench for the periodic subscription table: directed and random items.
module testbench;

   localparam int DEPTH           = pst_pkg::TABLE_DEPTH_DEF;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 76;
   localparam int SETTLE_CYCLES   = 40;
   localparam int STUCK_LIMIT     = 4000;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [1:0] FN_IGNORED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   pst_pkg::pst_req_type          req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   pst_pkg::pst_rsp_type          rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pst_pkg::CSR_IDX_W-1:0] csr_index = pst_pkg::CSR_LIFETIME;
   logic [31:0]                   csr_wdata = '0;

   // Items waiting to be sent, and results owed by the block
   pst_pkg::pst_req_type pending_items[$];
   pst_pkg::pst_rsp_type owed_results[$];

   // Shadow of the subscription table and its registers
   logic [31:0] cfg_lifetime = pst_pkg::LIFETIME_RST;
   logic [7:0]  cfg_own      = pst_pkg::OWN_ADDR_RST;
   logic [31:0] shadow_ms    = '0;
   int          shadow_count = 0;
   logic [7:0]  shadow_resource[DEPTH];
   logic [7:0]  shadow_dest[DEPTH];
   logic [7:0]  shadow_kind[DEPTH];
   logic [3:0]  shadow_length[DEPTH];
   logic [15:0] shadow_period[DEPTH];
   logic [31:0] shadow_due[DEPTH];
   logic [31:0] shadow_expiry[DEPTH];
   bit          shadow_forever[DEPTH];

   int fail_count   = 0;
   int stuck_cycles = 0;

   // Sender burst shaping and receiver stall pattern
   int burst_left = 1;
   int gap_left   = 0;
   int stall_beat = 0;
   int stall_run  = 0;

   periodic_subscription_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Slot holding a resource id, or -1
   function automatic int find_slot(input logic [7:0] rid);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_resource[i] == rid) return i;
      end
      return -1;
   endfunction

   // Remove one entry and close the gap
   function automatic void drop_slot(input int k);
      for (int j = k; j + 1 < shadow_count; j++) begin
         shadow_resource[j] = shadow_resource[j + 1];
         shadow_dest[j]     = shadow_dest[j + 1];
         shadow_kind[j]     = shadow_kind[j + 1];
         shadow_length[j]   = shadow_length[j + 1];
         shadow_period[j]   = shadow_period[j + 1];
         shadow_due[j]      = shadow_due[j + 1];
         shadow_expiry[j]   = shadow_expiry[j + 1];
         shadow_forever[j]  = shadow_forever[j + 1];
      end
      if (shadow_count > 0) shadow_count--;
   endfunction

   function automatic void owe_ack(input logic [2:0] status);
      pst_pkg::pst_rsp_type ack;
      ack        = '0;
      ack.status = status;
      ack.last   = 1'b1;
      owed_results.push_back(ack);
   endfunction

   // One result as text
   function automatic string show_result(input pst_pkg::pst_rsp_type r);
      return $sformatf("rep=%0b st=%0d res=%h dst=%h src=%h kind=%h len=%0d last=%0b",
                       r.is_report, r.status, r.report_resource, r.report_dest,
                       r.report_source, r.report_kind, r.report_length, r.last);
   endfunction

   // Update the shadow table for one accepted item and queue what it owes
   function automatic void apply_subscription_item(input pst_pkg::pst_req_type item);
      pst_pkg::pst_rsp_type rpt;
      pst_pkg::pst_rsp_type held;
      bit                   have_held;
      int                   k;
      int                   i;
      int                   n;
      have_held = 1'b0;
      n = 0;
      case (item.func)
         pst_pkg::FN_SUB: begin
            if (shadow_count >= DEPTH) begin
               owe_ack(pst_pkg::ST_FULL);
            end else begin
               k = find_slot(item.resource_id);
               if (k >= 0) begin
                  // renewal keeps destination, type, length and due time
                  shadow_period[k]  = item.period_ms;
                  shadow_expiry[k]  = shadow_ms + cfg_lifetime;
                  shadow_forever[k] = 1'b0;
                  owe_ack(pst_pkg::ST_RENEWED);
               end else begin
                  k = shadow_count;
                  shadow_resource[k] = item.resource_id;
                  shadow_dest[k]     = item.dest_addr;
                  shadow_kind[k]     = item.report_type;
                  shadow_length[k]   = item.payload_bytes;
                  shadow_period[k]   = item.period_ms;
                  shadow_due[k]      = shadow_ms + item.period_ms;
                  shadow_expiry[k]   = item.with_lifetime ? shadow_ms + cfg_lifetime : '1;
                  shadow_forever[k]  = !item.with_lifetime;
                  shadow_count++;
                  owe_ack(pst_pkg::ST_INSERTED);
               end
            end
         end
         pst_pkg::FN_UNSUB: begin
            k = find_slot(item.resource_id);
            if (k < 0) begin
               owe_ack(pst_pkg::ST_NOT_FOUND);
            end else begin
               drop_slot(k);
               owe_ack(pst_pkg::ST_REMOVED);
            end
         end
         pst_pkg::FN_TICK: begin
            shadow_ms = shadow_ms + 32'd1;
            i = 0;
            // scan in order; after a removal the same slot is looked at again
            while (i < shadow_count) begin
               if (shadow_due[i] <= shadow_ms) begin
                  rpt                 = '0;
                  rpt.is_report       = 1'b1;
                  rpt.status          = pst_pkg::ST_REPORT;
                  rpt.report_resource = shadow_resource[i];
                  rpt.report_dest     = shadow_dest[i];
                  rpt.report_source   = cfg_own;
                  rpt.report_kind     = shadow_kind[i];
                  rpt.report_length   = shadow_length[i];
                  if (n < pst_pkg::MAX_RESULTS) begin
                     if (have_held) owed_results.push_back(held);
                     held      = rpt;
                     have_held = 1'b1;
                     n++;
                  end
                  shadow_due[i] = shadow_ms + shadow_period[i];
               end
               if (!shadow_forever[i] && shadow_expiry[i] <= shadow_ms) drop_slot(i);
               else i++;
            end
            if (have_held) begin
               held.last = 1'b1;
               owed_results.push_back(held);
            end else begin
               owe_ack(pst_pkg::ST_NOTHING_DUE);
            end
         end
         default: begin
            // unused function code: no result, no change
         end
      endcase
   endfunction

   function automatic pst_pkg::pst_req_type make_item(input logic [1:0] fn,
                                                      input logic [7:0] rid,
                                                      input logic [7:0] dest,
                                                      input logic [7:0] kind,
                                                      input logic [3:0] len,
                                                      input logic [15:0] period,
                                                      input logic lt);
      pst_pkg::pst_req_type item;
      item.func          = fn;
      item.resource_id   = rid;
      item.dest_addr     = dest;
      item.report_type   = kind;
      item.payload_bytes = len;
      item.period_ms     = period;
      item.with_lifetime = lt;
      return item;
   endfunction

   // Random item: ids mostly from a small pool so renewals and removals hit
   function automatic pst_pkg::pst_req_type random_item();
      pst_pkg::pst_req_type item;
      int pick;
      item = make_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       4'($urandom_range(0, 8)), 16'($urandom), 1'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 38) item.func = pst_pkg::FN_SUB;
      else if (pick < 55) item.func = pst_pkg::FN_UNSUB;
      else if (pick < 96) item.func = pst_pkg::FN_TICK;
      else item.func = FN_IGNORED;
      if ($urandom_range(0, 9) < 7) item.resource_id = 8'($urandom_range(0, 23));
      if ($urandom_range(0, 9) < 2) item.payload_bytes = 4'($urandom_range(9, 15));
      pick = $urandom_range(0, 99);
      if (pick < 60) item.period_ms = 16'($urandom_range(0, 6));
      else if (pick < 85) item.period_ms = 16'($urandom_range(7, 40));
      return item;
   endfunction

   // Wait until the block has nothing left to do
   task automatic drain_and_settle();
      while (pending_items.size() != 0 || req_valid || owed_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back, called at a clock edge
   task automatic apply_settings(input logic [31:0] lifetime, input logic [7:0] own);
      csr_valid <= 1'b1;
      csr_index <= pst_pkg::CSR_LIFETIME;
      csr_wdata <= lifetime;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_lifetime = lifetime;
      csr_index <= pst_pkg::CSR_OWN_ADDR;
      csr_wdata <= {24'd0, own};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_own = own;
      csr_valid <= 1'b0;
   endtask

   // Sender: bursts of items with random gaps, data held while stalled
   always @(posedge clock) begin : drive_items
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_subscription_item(req_data);
         if (!req_valid || !req_stall) begin
            send = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               send = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
            req_valid <= send;
         end
      end
   end

   // Receiver: checks results; stall pattern rotates among none, random and alternating runs
   always @(posedge clock) begin : check_results
      pst_pkg::pst_rsp_type want;
      logic                 hold;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected result: %s", show_result(rsp_data));
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.is_report !== want.is_report || rsp_data.status !== want.status ||
                   rsp_data.report_resource !== want.report_resource ||
                   rsp_data.report_dest !== want.report_dest ||
                   rsp_data.report_source !== want.report_source ||
                   rsp_data.report_kind !== want.report_kind ||
                   rsp_data.report_length !== want.report_length ||
                   rsp_data.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("mismatch expected: %s", show_result(want));
                     $display("         actual:   %s", show_result(rsp_data));
                  end
               end
            end
         end
         stall_beat++;
         case ((stall_beat / 250) % 3)
            0: hold = 1'b0;
            1: hold = ($urandom_range(0, 3) == 0);
            default: begin
               // alternating runs of stall and flow
               if (stall_run > 0) begin
                  stall_run--;
                  hold = rsp_stall;
               end else begin
                  hold = !rsp_stall;
                  stall_run = hold ? $urandom_range(0, 7) : $urandom_range(0, 10);
               end
            end
         endcase
         rsp_stall <= hold;
      end
   end

   // Count cycles in which no handshake completes
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin : watchdog
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("periodic_subscription_table verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] lifetime;
      logic [7:0]  own;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, absent id, field extremes, renewal of a permanent entry
      pending_items.push_back(make_item(pst_pkg::FN_TICK, 8'h00, 8'h00, 8'h00, 4'd0,
                                        16'd0, 1'b0));
      pending_items.push_back(make_item(pst_pkg::FN_UNSUB, 8'h7E, 8'hFF, 8'hFF, 4'hF,
                                        16'hFFFF, 1'b1));
      pending_items.push_back(make_item(pst_pkg::FN_SUB, 8'h00, 8'hFF, 8'h00, 4'd0,
                                        16'd0, 1'b0));
      pending_items.push_back(make_item(pst_pkg::FN_SUB, 8'hFF, 8'h00, 8'hFF, 4'hF,
                                        16'hFFFF, 1'b1));
      pending_items.push_back(make_item(pst_pkg::FN_SUB, 8'h00, 8'h55, 8'hAA, 4'd8,
                                        16'd1, 1'b1));
      pending_items.push_back(make_item(pst_pkg::FN_TICK, 8'hFF, 8'hFF, 8'hFF, 4'hF,
                                        16'hFFFF, 1'b1));
      pending_items.push_back(make_item(FN_IGNORED, 8'h00, 8'h00, 8'h00, 4'd0, 16'd0, 1'b0));
      pending_items.push_back(make_item(pst_pkg::FN_UNSUB, 8'hFF, 8'h00, 8'h00, 4'd0,
                                        16'd0, 1'b0));
      // Fill the table, then a subscribe to an existing id is still refused
      for (int r = 1; r < DEPTH; r++)
         pending_items.push_back(make_item(pst_pkg::FN_SUB, 8'(r), 8'(r * 17), 8'(255 - r),
                                           4'(r % 9), 16'd1, 1'(r % 2)));
      pending_items.push_back(make_item(pst_pkg::FN_SUB, 8'h00, 8'h12, 8'h34, 4'd3,
                                        16'd2, 1'b1));
      // A full scan with every entry due
      pending_items.push_back(make_item(pst_pkg::FN_TICK, 8'h00, 8'h00, 8'h00, 4'd0,
                                        16'd0, 1'b0));
      drain_and_settle();

      // Random phases over several register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin lifetime = 32'd1;          own = 8'hFF; end
            1: begin lifetime = 32'd4;          own = 8'h5A; end
            2: begin lifetime = 32'hFFFF_FFFF;  own = 8'h00; end
            3: begin lifetime = 32'd12;         own = 8'hA5; end
            4: begin lifetime = 32'd40;         own = 8'h3C; end
            default: begin lifetime = 32'd5000; own = 8'h81; end
         endcase
         apply_settings(lifetime, own);
         repeat (ITEMS_PER_PHASE) pending_items.push_back(random_item());
         drain_and_settle();
      end

      if (fail_count == 0 && owed_results.size() == 0)
         $display("periodic_subscription_table verification clean");
      else
         $display("periodic_subscription_table verification failed");
      $finish;
   end

endmodule
